// ===== hdl/rlgn_pkg.sv =====
// Package with shared constants, types and the lane merge function of the realigner.
`timescale 1ns / 1ps

package rlgn_pkg;

    localparam int COUNT_BITS = 24;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_ALIGN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_ALIGN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BYTE_COUNT = 2'd2;

    typedef struct packed {
        logic       k;
        logic [2:0] kl;
        logic [5:0] s_mid;
        logic [5:0] s_last;
        logic [3:0] lo_mask;
        logic [3:0] hi_mask;
        logic       bc_zero;
    } t_cfg;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  be;
        logic        last;
    } t_res;

    function automatic logic [31:0] merge_lanes(input logic [63:0] pair,
                                                input logic [5:0]  shift,
                                                input logic [3:0]  be);
        logic [31:0] word;
        logic [5:0]  q;
        word = '0;
        for (int b = 0; b < 4; b++) begin
            q = shift + 6'(b);
            if (be[b] && (q < 6'd8)) begin
                word[8*b +: 8] = pair[{q[2:0], 3'b000} +: 8];
            end
        end
        return word;
    endfunction

endpackage

// ===== hdl/unaligned_word_copy_realigner_top.sv =====
// Top level of the unaligned word copy realigner.
//
//  Channel   Direction  Handshake                 Beat payload
//  in        sink       i_in_valid / o_in_stall   i_src_word
//  out       source     o_out_valid / i_out_stall o_dest_word, o_byte_enable, o_last_word
//  cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One source word is taken per cycle while o_in_stall is low; a result passes through
// the input and result registers. A word completing two destination words stalls the
// next input word, as the result register drains one beat per cycle while not stalled.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stall on the output backs up through the result register into the input register.
`timescale 1ns / 1ps

module unaligned_word_copy_realigner_top #(
    parameter int COUNT_BITS = rlgn_pkg::COUNT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [31:0]                       i_src_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [31:0]                       o_dest_word,
    output logic [3:0]                        o_byte_enable,
    output logic                              o_last_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rlgn_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COUNT_BITS-1:0]             i_cfg_data
);

    rlgn_pkg::t_cfg        w_cfg;
    rlgn_pkg::t_res        w_res0;
    rlgn_pkg::t_res        w_res1;
    logic                  w_wr;
    logic [COUNT_BITS-2:0] w_nd;
    logic                  w_free;
    logic                  w_load;
    logic [1:0]            w_num;
    logic [1:0]            w_out_cnt;
    logic                  w_in_full;

    rlgn_cfg #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr        (w_wr),
        .o_cfg       (w_cfg),
        .o_nd        (w_nd)
    );

    rlgn_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_src_word (i_src_word),
        .i_abort    (w_wr),
        .i_cfg      (w_cfg),
        .i_nd       (w_nd),
        .i_free     (w_free),
        .o_in_full  (w_in_full),
        .o_load     (w_load),
        .o_num      (w_num),
        .o_res0     (w_res0),
        .o_res1     (w_res1)
    );

    rlgn_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_num         (w_num),
        .i_res0        (w_res0),
        .i_res1        (w_res1),
        .o_free        (w_free),
        .o_cnt         (w_out_cnt),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_dest_word   (o_dest_word),
        .o_byte_enable (o_byte_enable),
        .o_last_word   (o_last_word)
    );

`ifndef SYNTH
    a_be_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_enable != 4'b0000))
        else $error("result beat with no byte enabled");

    a_lanes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_dest_word & {{8{o_byte_enable[3]}}, {8{o_byte_enable[2]}},
                                         {8{o_byte_enable[1]}}, {8{o_byte_enable[0]}}})
                         == o_dest_word))
        else $error("disabled byte lane carries data");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_full && (w_out_cnt == 2'd2)) |-> o_in_stall)
        else $error("input taken while result register is full");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (w_free && (w_num != 2'd0)))
        else $error("result register loaded while occupied");
`endif

endmodule

// ===== hdl/rlgn_cfg.sv =====
// Configuration registers and the copy geometry derived from them.
`timescale 1ns / 1ps

module rlgn_cfg #(
    parameter int COUNT_BITS = rlgn_pkg::COUNT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rlgn_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COUNT_BITS-1:0]             i_cfg_data,
    output logic                              o_wr,
    output rlgn_pkg::t_cfg                    o_cfg,
    output logic [COUNT_BITS-2:0]             o_nd
);

    logic [1:0]            r_sa, n_sa;
    logic [1:0]            r_da, n_da;
    logic [COUNT_BITS-1:0] r_bc, n_bc;
    logic [COUNT_BITS-2:0] r_nd, n_nd;
    logic                  r_bc_zero;
    logic [COUNT_BITS:0]   w_sum;
    logic [1:0]            w_r;
    logic [2:0]            w_a;
    logic [2:0]            w_b;
    logic [1:0]            w_e;

    assign o_cfg_ready = 1'b1;
    assign o_wr = i_cfg_valid && ((i_cfg_index == rlgn_pkg::CFG_SRC_ALIGN) ||
                                  (i_cfg_index == rlgn_pkg::CFG_DST_ALIGN) ||
                                  (i_cfg_index == rlgn_pkg::CFG_BYTE_COUNT));

    always_comb begin
        n_sa = r_sa;
        n_da = r_da;
        n_bc = r_bc;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rlgn_pkg::CFG_SRC_ALIGN:  n_sa = i_cfg_data[1:0];
                rlgn_pkg::CFG_DST_ALIGN:  n_da = i_cfg_data[1:0];
                rlgn_pkg::CFG_BYTE_COUNT: n_bc = i_cfg_data;
                default: ;
            endcase
        end
        w_sum = {1'b0, n_bc} + {{(COUNT_BITS-1){1'b0}}, n_da} - {{COUNT_BITS{1'b0}}, 1'b1};
        n_nd = w_sum[COUNT_BITS:2] + {{(COUNT_BITS-2){1'b0}}, 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa      <= '0;
            r_da      <= '0;
            r_bc      <= '0;
            r_nd      <= '0;
            r_bc_zero <= 1'b1;
        end else begin
            r_sa      <= n_sa;
            r_da      <= n_da;
            r_bc      <= n_bc;
            r_nd      <= n_nd;
            r_bc_zero <= (n_bc == '0);
        end
    end

    always_comb begin
        w_r = r_bc[1:0] - 2'd1;
        w_a = {1'b0, r_sa} + {1'b0, w_r};
        w_b = {1'b0, r_da} + {1'b0, w_r};
        w_e = r_da + w_r;
        o_cfg.k       = (r_sa > r_da);
        o_cfg.kl      = {2'b00, w_a[2]} - {2'b00, w_b[2]};
        o_cfg.s_mid   = {4'b0000, r_sa} - {4'b0000, r_da} + 6'd4
                        - (o_cfg.k ? 6'd4 : 6'd0);
        o_cfg.s_last  = {4'b0000, r_sa} - {4'b0000, r_da} + 6'd4
                        - {o_cfg.kl[2], o_cfg.kl, 2'b00};
        o_cfg.lo_mask = 4'b1111 << r_da;
        o_cfg.hi_mask = 4'b1111 >> (2'd3 - w_e);
        o_cfg.bc_zero = r_bc_zero;
    end

    assign o_nd = r_nd;

endmodule

// ===== hdl/rlgn_core.sv =====
// Input register, copy progress state and the merge of held and current source words.
`timescale 1ns / 1ps

module rlgn_core #(
    parameter int COUNT_BITS = rlgn_pkg::COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [31:0]           i_src_word,
    input  logic                  i_abort,
    input  rlgn_pkg::t_cfg        i_cfg,
    input  logic [COUNT_BITS-2:0] i_nd,
    input  logic                  i_free,
    output logic                  o_in_full,
    output logic                  o_load,
    output logic [1:0]            o_num,
    output rlgn_pkg::t_res        o_res0,
    output rlgn_pkg::t_res        o_res1
);

    localparam int RW = COUNT_BITS - 1;

    logic          r_in_vld;
    logic [31:0]   r_in_word;
    logic          r_active;
    logic [RW-1:0] r_rem;
    logic [2:0]    r_d;
    logic          r_w0;
    logic [31:0]   r_held;

    logic          w_proc;
    logic          w_start;
    logic          w_go;
    logic [63:0]   w_pair;
    logic [2:0]    w_d;
    logic          w_w0;
    logic [RW-1:0] w_rem;
    logic          w_last1;
    logic          w_last2;
    logic [2:0]    w_k1;
    logic [2:0]    w_k2;
    logic          w_e1;
    logic          w_e2;
    logic [3:0]    w_be1;
    logic [3:0]    w_be2;
    logic [RW-1:0] w_rem_next;

    assign w_proc     = r_in_vld && i_free;
    assign o_in_stall = r_in_vld && !i_free;
    assign o_in_full  = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_src_word;
        end
    end

    always_comb begin
        w_start = !r_active;
        w_go    = w_proc && !(w_start && i_cfg.bc_zero);
        w_pair  = {r_in_word, (w_start ? 32'd0 : r_held)};
        w_d     = w_start ? 3'd0 : r_d;
        w_w0    = w_start ? 1'b1 : r_w0;
        w_rem   = w_start ? i_nd : r_rem;
        w_last1 = (w_rem == RW'(1));
        w_last2 = (w_rem == RW'(2));
        w_k1    = w_last1 ? i_cfg.kl : {2'b00, i_cfg.k};
        w_k2    = w_last2 ? i_cfg.kl : {2'b00, i_cfg.k};
        w_e1    = w_go && (w_d == w_k1);
        w_e2    = w_e1 && !w_last1 && ((w_d - 3'd1) == w_k2);
        w_be1   = (w_w0 ? i_cfg.lo_mask : 4'b1111) & (w_last1 ? i_cfg.hi_mask : 4'b1111);
        w_be2   = w_last2 ? i_cfg.hi_mask : 4'b1111;

        o_res0.word = rlgn_pkg::merge_lanes(w_pair,
                                            w_last1 ? i_cfg.s_last : i_cfg.s_mid, w_be1);
        o_res0.be   = w_be1;
        o_res0.last = w_last1;
        o_res1.word = rlgn_pkg::merge_lanes(w_pair,
                                            w_last2 ? i_cfg.s_last : i_cfg.s_mid, w_be2);
        o_res1.be   = w_be2;
        o_res1.last = w_last2;

        o_num      = w_e2 ? 2'd2 : (w_e1 ? 2'd1 : 2'd0);
        o_load     = w_go && w_e1;
        w_rem_next = w_rem - {{(RW-2){1'b0}}, o_num};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_abort) begin
            r_active <= 1'b0;
        end else if (w_go) begin
            r_active <= (w_rem_next != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_rem  <= w_rem_next;
            r_d    <= w_d + 3'd1 - {1'b0, o_num};
            r_w0   <= w_w0 && !w_e1;
            r_held <= r_in_word;
        end
    end

endmodule

// ===== hdl/rlgn_out.sv =====
// Two-entry result register that hands destination words out one beat at a time.
`timescale 1ns / 1ps

module rlgn_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic [1:0]     i_num,
    input  rlgn_pkg::t_res i_res0,
    input  rlgn_pkg::t_res i_res1,
    output logic           o_free,
    output logic [1:0]     o_cnt,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [31:0]    o_dest_word,
    output logic [3:0]     o_byte_enable,
    output logic           o_last_word
);

    logic [1:0]     r_cnt;
    rlgn_pkg::t_res r_slot0;
    rlgn_pkg::t_res r_slot1;
    logic           w_take;

    assign w_take      = (r_cnt != 2'd0) && !i_out_stall;
    assign o_free      = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_take);
    assign o_cnt       = r_cnt;
    assign o_out_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_num;
        end else if (w_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_res0;
            r_slot1 <= i_res1;
        end else if (w_take) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_dest_word   = r_slot0.word;
    assign o_byte_enable = r_slot0.be;
    assign o_last_word   = r_slot0.last;

endmodule
